FILE: sv/dqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dqs_pkg;

  typedef enum logic [1:0] {
    OP_POLL      = 2'd0,
    OP_CONSUME   = 2'd1,
    OP_SET_READY = 2'd2,
    OP_NOP       = 2'd3
  } op_e;

  localparam logic [2:0] REG_ACTIVE_QUEUES = 3'd0;
  localparam logic [2:0] REG_MAX_BURST     = 3'd4;

  localparam logic [4:0]  ACTIVE_RESET = 5'd16;
  localparam logic [15:0] BURST_RESET  = 16'd32;

  typedef struct packed {
    op_e         op;
    logic        bell;
    logic        q_ok;
    logic [3:0]  queue;
    logic [15:0] count;
    logic [63:0] stamp;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  active;
    logic [15:0] burst;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONS,
    S_BELL,
    S_SSTART,
    S_SCAN,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: sv/dqs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dqs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: sv/dqs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dqs_front
  import dqs_pkg::*;
#(
  parameter int QUEUES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic        doorbell_valid_i,
  input  wire logic [3:0]  queue_i,
  input  wire logic [15:0] doorbell_count_i,
  input  wire logic [15:0] received_count_i,
  input  wire logic [63:0] now_i,
  input  wire logic [63:0] ready_value_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  wire logic        cmd_pop_i
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  cmd_t       cmd_in;
  logic       push;
  logic       pop;

  always_comb begin
    cmd_in.op    = op_e'(operation_i);
    cmd_in.q_ok  = 32'(queue_i) < QUEUES;
    cmd_in.bell  = doorbell_valid_i && cmd_in.q_ok;
    cmd_in.queue = queue_i;
    cmd_in.count = (cmd_in.op == OP_CONSUME) ? received_count_i : doorbell_count_i;
    cmd_in.stamp = (cmd_in.op == OP_SET_READY) ? ready_value_i : now_i;
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dqs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dqs_back
  import dqs_pkg::*;
#(
  parameter int QUEUES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        cmd_valid_i,
  input  wire cmd_t        cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             found_o,
  output logic [3:0]       selected_queue_o,
  output logic [15:0]      grant_count_o
);

  localparam int IW = $clog2(QUEUES);
  localparam int CW = $clog2(QUEUES + 1);

  state_e state_q, state_d;
  cmd_t   cur_q, cur_d;

  logic [IW-1:0]     raddr, rd_addr_q;
  logic [CW-1:0]     t_q, t_d;
  logic [IW-1:0]     ptr_q, ptr_d;
  logic              res_found_q, res_found_d;
  logic [IW-1:0]     res_sel_q, res_sel_d;
  logic [15:0]       res_grant_q, res_grant_d;
  logic              out_vld_q, out_vld_d;
  logic              out_found_q;
  logic [3:0]        out_sel_q;
  logic [15:0]       out_grant_q;
  logic              load_out;

  logic [QUEUES-1:0] cnt_vld_q, rdy_vld_q;
  logic              cnt_we, rdy_we;
  logic [IW-1:0]     cnt_waddr, rdy_waddr;
  logic [15:0]       cnt_wdata;
  logic [15:0]       cnt_ram, cnt_rd;
  logic [63:0]       rdy_ram, rdy_rd;

  logic [CW-1:0]     n_act;
  logic [IW-1:0]     start;
  logic [IW-1:0]     nxt;
  logic              last;
  logic              scan_hit;
  logic              bell_hit;
  logic [16:0]       sum;
  logic [15:0]       sat_add, sat_sub;
  logic [IW-1:0]     head_idx, cur_idx;

  dqs_ram #(.WIDTH(16), .DEPTH(QUEUES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (raddr),
    .rdata_o (cnt_ram)
  );

  dqs_ram #(.WIDTH(64), .DEPTH(QUEUES)) u_rdy_ram (
    .clk_i   (clk_i),
    .we_i    (rdy_we),
    .waddr_i (rdy_waddr),
    .wdata_i (cmd_i.stamp),
    .raddr_i (raddr),
    .rdata_o (rdy_ram)
  );

  function automatic logic [15:0] limit(input logic [15:0] c, input logic [15:0] b);
    return (c > b) ? b : c;
  endfunction

  always_comb begin
    if (cfg_i.active == 5'd0) begin
      n_act = CW'(1);
    end else if (32'(cfg_i.active) > QUEUES) begin
      n_act = CW'(QUEUES);
    end else begin
      n_act = CW'(cfg_i.active);
    end
    start    = (CW'(ptr_q) < n_act) ? ptr_q : '0;
    nxt      = (CW'(rd_addr_q) + CW'(1) == n_act) ? '0 : rd_addr_q + IW'(1);
    last     = (t_q == n_act - CW'(1));
    head_idx = IW'(cmd_i.queue);
    cur_idx  = IW'(cur_q.queue);
    cnt_rd   = cnt_vld_q[rd_addr_q] ? cnt_ram : 16'd0;
    rdy_rd   = rdy_vld_q[rd_addr_q] ? rdy_ram : 64'd0;
    scan_hit = (cnt_rd != 16'd0) && (rdy_rd < cur_q.stamp);
    bell_hit = (rdy_rd <= cur_q.stamp);
    sum      = {1'b0, cnt_rd} + {1'b0, cur_q.count};
    sat_add  = sum[16] ? 16'hFFFF : sum[15:0];
    sat_sub  = (cnt_rd > cur_q.count) ? cnt_rd - cur_q.count : 16'd0;
    load_out = !out_vld_q || out_ready_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          priority if (cmd_i.op == OP_CONSUME && cmd_i.q_ok) state_d = S_CONS;
          else if (cmd_i.op == OP_POLL && cmd_i.bell)       state_d = S_BELL;
          else if (cmd_i.op == OP_POLL)                     state_d = S_SSTART;
          else                                              state_d = S_DONE;
        end
      end
      S_CONS:   state_d = S_DONE;
      S_BELL:   state_d = bell_hit ? S_DONE : S_SSTART;
      S_SSTART: state_d = S_SCAN;
      S_SCAN:   state_d = (scan_hit || last) ? S_DONE : S_SCAN;
      S_DONE:   state_d = load_out ? S_IDLE : S_DONE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_pop_o   = 1'b0;
    cur_d       = cur_q;
    raddr       = head_idx;
    t_d         = t_q;
    ptr_d       = ptr_q;
    res_found_d = res_found_q;
    res_sel_d   = res_sel_q;
    res_grant_d = res_grant_q;
    cnt_we      = 1'b0;
    cnt_waddr   = cur_idx;
    cnt_wdata   = sat_add;
    rdy_we      = 1'b0;
    rdy_waddr   = head_idx;
    out_vld_d   = out_vld_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        res_found_d = 1'b0;
        res_sel_d   = '0;
        res_grant_d = 16'd0;
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          rdy_we    = (cmd_i.op == OP_SET_READY) && cmd_i.q_ok;
        end
      end
      S_CONS: begin
        cnt_we    = 1'b1;
        cnt_wdata = sat_sub;
      end
      S_BELL: begin
        cnt_we = 1'b1;
        if (bell_hit) begin
          res_found_d = 1'b1;
          res_sel_d   = cur_idx;
          res_grant_d = limit(cur_q.count, cfg_i.burst);
        end
      end
      S_SSTART: begin
        raddr = start;
        t_d   = '0;
      end
      S_SCAN: begin
        raddr = nxt;
        t_d   = t_q + CW'(1);
        if (scan_hit) begin
          res_found_d = 1'b1;
          res_sel_d   = rd_addr_q;
          res_grant_d = limit(cnt_rd, cfg_i.burst);
          ptr_d       = rd_addr_q;
        end else if (last) begin
          ptr_d = start;
        end
      end
      S_DONE: begin
        if (load_out) out_vld_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ptr_q     <= '0;
      out_vld_q <= 1'b0;
      cnt_vld_q <= '0;
      rdy_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      out_vld_q <= out_vld_d;
      if (cnt_we) cnt_vld_q[cnt_waddr] <= 1'b1;
      if (rdy_we) rdy_vld_q[rdy_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    rd_addr_q   <= raddr;
    t_q         <= t_d;
    res_found_q <= res_found_d;
    res_sel_q   <= res_sel_d;
    res_grant_q <= res_grant_d;
    if (state_q == S_DONE && load_out) begin
      out_found_q <= res_found_q;
      out_sel_q   <= 4'(res_sel_q);
      out_grant_q <= res_grant_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign found_o          = out_found_q;
  assign selected_queue_o = out_sel_q;
  assign grant_count_o    = out_grant_q;

endmodule

`default_nettype wire

FILE: sv/doorbell_queue_selector.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake                 Payload
// input    in_valid_i / in_ready_o   operation, doorbell_valid, queue, counts, now, ready_value
// output   out_valid_o / out_ready_i found, selected_queue, grant_count
// config   APB psel/penable/pwrite   active_queues at 0x0, max_burst at 0x4
//
// With the back idle, a ready-time write or code 3 goes from IDLE straight to DONE, an in-range
// consume via CONS, a doorbell grant via BELL, a poll via SSTART and SCAN (BELL first if its
// doorbell misses); SCAN reads one queue a cycle, at most active_queues clamped to 1..QUEUES.
// A two-beat command queue lets the front accept while the back is busy.
// Reset clears the per-queue valid bits at once; no clearing pass is needed.
// A stalled output holds its beat and the back waits in its final state.

module doorbell_queue_selector
  import dqs_pkg::*;
#(
  parameter int QUEUES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic        doorbell_valid_i,
  input  wire logic [3:0]  queue_i,
  input  wire logic [15:0] doorbell_count_i,
  input  wire logic [15:0] received_count_i,
  input  wire logic [63:0] now_i,
  input  wire logic [63:0] ready_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             found_o,
  output logic [3:0]       selected_queue_o,
  output logic [15:0]      grant_count_o
);

  cfg_t cfg_q;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active <= ACTIVE_RESET;
      cfg_q.burst  <= BURST_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_MAX_BURST[2]) begin
        cfg_q.burst <= pwdata[15:0];
      end else begin
        cfg_q.active <= pwdata[4:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MAX_BURST[2]) ? {16'd0, cfg_q.burst}
                                                 : {27'd0, cfg_q.active};

  dqs_front #(.QUEUES(QUEUES)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .doorbell_valid_i (doorbell_valid_i),
    .queue_i          (queue_i),
    .doorbell_count_i (doorbell_count_i),
    .received_count_i (received_count_i),
    .now_i            (now_i),
    .ready_value_i    (ready_value_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  dqs_back #(.QUEUES(QUEUES)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .cmd_pop_o        (cmd_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_o          (found_o),
    .selected_queue_o (selected_queue_o),
    .grant_count_o    (grant_count_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb_doorbell_queue_selector.sv
`timescale 1ns / 1ps

module tb_doorbell_queue_selector;
  import dqs_pkg::*;

  localparam int QUEUES      = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    op_e         op;
    logic        bell;
    logic [3:0]  queue;
    logic [15:0] bell_cnt;
    logic [15:0] rx_cnt;
    logic [63:0] now;
    logic [63:0] ready;
  } beat_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  sel;
    logic [15:0] grant;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = '0;
  logic        doorbell_valid = 1'b0;
  logic [3:0]  queue = '0;
  logic [15:0] doorbell_count = '0;
  logic [15:0] received_count = '0;
  logic [63:0] now = '0;
  logic [63:0] ready_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [3:0]  selected_queue;
  logic [15:0] grant_count;

  // predictor state
  logic [15:0] pend_cnt [QUEUES];
  logic [63:0] ready_at [QUEUES];
  logic [3:0]  rr_ptr;
  logic [4:0]  cfg_active;
  logic [15:0] cfg_burst;

  grant_t      grant_q [$];
  int          errors;
  int          cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic [63:0] traffic_time;

  doorbell_queue_selector #(.QUEUES(QUEUES)) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .operation_i      (operation),
    .doorbell_valid_i (doorbell_valid),
    .queue_i          (queue),
    .doorbell_count_i (doorbell_count),
    .received_count_i (received_count),
    .now_i            (now),
    .ready_value_i    (ready_value),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .found_o          (found),
    .selected_queue_o (selected_queue),
    .grant_count_o    (grant_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int scan_width();
    int n;
    n = cfg_active;
    if (n == 0) n = 1;
    if (n > QUEUES) n = QUEUES;
    return n;
  endfunction

  function automatic logic [15:0] burst_cap(logic [15:0] c);
    return (c > cfg_burst) ? cfg_burst : c;
  endfunction

  function automatic grant_t predict_grant(beat_t b);
    grant_t      r;
    logic [16:0] sum;
    logic        hit;
    int          n;
    int          p;
    int          t;
    r   = '0;
    hit = 1'b0;
    case (b.op)
      OP_POLL: begin
        if (b.bell) begin
          sum = {1'b0, pend_cnt[b.queue]} + {1'b0, b.bell_cnt};
          pend_cnt[b.queue] = sum[16] ? 16'hFFFF : sum[15:0];
          if (ready_at[b.queue] <= b.now) begin
            hit     = 1'b1;
            r.sel   = b.queue;
            r.grant = burst_cap(b.bell_cnt);
          end
        end
        if (!hit) begin
          n = scan_width();
          p = (rr_ptr < n) ? rr_ptr : 0;
          t = 0;
          while (t < n && !hit) begin
            if (pend_cnt[p] != 0 && ready_at[p] < b.now) begin
              hit     = 1'b1;
              r.sel   = p[3:0];
              r.grant = burst_cap(pend_cnt[p]);
            end else begin
              p = (p + 1 == n) ? 0 : p + 1;
              t++;
            end
          end
          rr_ptr = p[3:0];
        end
        r.found = hit;
        if (!hit) r = '0;
      end
      OP_CONSUME: begin
        pend_cnt[b.queue] = (pend_cnt[b.queue] > b.rx_cnt) ?
                            pend_cnt[b.queue] - b.rx_cnt : 16'd0;
      end
      OP_SET_READY: begin
        ready_at[b.queue] = b.ready;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin : result_check
    grant_t want;
    if (rst_n) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (out_valid && out_ready) begin
      if (grant_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = grant_q.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          errors++;
        end
        if (selected_queue !== want.sel) begin
          $error("selected_queue: expected %0d, got %0d", want.sel, selected_queue);
          errors++;
        end
        if (grant_count !== want.grant) begin
          $error("grant_count: expected %0d, got %0d", want.grant, grant_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[doorbell_queue_selector] ERROR");
      $finish;
    end
  end

  task automatic send_beat(beat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    operation      <= b.op;
    doorbell_valid <= b.bell;
    queue          <= b.queue;
    doorbell_count <= b.bell_cnt;
    received_count <= b.rx_cnt;
    now            <= b.now;
    ready_value    <= b.ready;
    do @(posedge clk_i); while (!in_ready);
    grant_q.push_back(predict_grant(b));
  endtask

  task automatic send_op(op_e op, logic bell, logic [3:0] q, logic [15:0] bc,
                         logic [15:0] rc, logic [63:0] t, logic [63:0] rv);
    beat_t b;
    b = '{op: op, bell: bell, queue: q, bell_cnt: bc, rx_cnt: rc, now: t, ready: rv};
    send_beat(b);
  endtask

  // hold the input until every expected beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == REG_ACTIVE_QUEUES) cfg_active = data[4:0];
    else if (addr == REG_MAX_BURST) cfg_burst = data[15:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic beat_t traffic_beat();
    beat_t b;
    int    pick;
    b    = '0;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      b = '{op: op_e'($urandom_range(0, 3)), bell: 1'($urandom_range(0, 1)),
            queue: 4'($urandom_range(0, 15)), bell_cnt: 16'($urandom),
            rx_cnt: 16'($urandom), now: {$urandom, $urandom},
            ready: {$urandom, $urandom}};
      return b;
    end
    b.queue = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, scan_width() - 1))
                                           : 4'($urandom_range(0, 15));
    if (pick < 55) begin
      traffic_time += $urandom_range(0, 20);
      b.op       = OP_POLL;
      b.bell     = ($urandom_range(0, 99) < 60);
      b.bell_cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(0, 40));
      b.now      = traffic_time;
    end else if (pick < 78) begin
      b.op     = OP_CONSUME;
      b.rx_cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    end else if (pick < 96) begin
      b.op = OP_SET_READY;
      case ($urandom_range(0, 9))
        0:       b.ready = '0;
        1:       b.ready = {$urandom, $urandom};
        default: b.ready = traffic_time + $urandom_range(0, 40);
      endcase
    end else begin
      b.op = OP_NOP;
    end
    return b;
  endfunction

  task automatic test_reset_state();
    send_op(OP_POLL, 1'b0, 4'd0, 16'd0, 16'd0, 64'd0, 64'd0);
    send_op(OP_POLL, 1'b0, 4'd15, 16'hFFFF, 16'hFFFF, '1, '1);
  endtask

  task automatic test_doorbell_grant();
    send_op(OP_POLL, 1'b1, 4'd3, 16'd0, 16'd0, 64'd0, 64'd0);
    send_op(OP_POLL, 1'b1, 4'd5, 16'hFFFF, 16'd0, 64'd0, 64'd0);
    send_op(OP_POLL, 1'b1, 4'd5, 16'hFFFF, 16'd0, 64'd1, 64'd0);
    send_op(OP_POLL, 1'b0, 4'd2, 16'd100, 16'd0, 64'd5, 64'd0);
  endtask

  task automatic test_consume_saturation();
    send_op(OP_CONSUME, 1'b0, 4'd5, 16'd0, 16'hFFFF, 64'd0, 64'd0);
    send_op(OP_CONSUME, 1'b1, 4'd3, 16'hFFFF, 16'd1, '1, '1);
    send_op(OP_POLL, 1'b1, 4'd15, 16'd9, 16'd0, '1, 64'd0);
    send_op(OP_CONSUME, 1'b0, 4'd15, 16'd0, 16'd4, 64'd0, 64'd0);
  endtask

  task automatic test_ready_time();
    send_op(OP_SET_READY, 1'b0, 4'd7, 16'd0, 16'd0, 64'd0, '1);
    send_op(OP_POLL, 1'b1, 4'd7, 16'd10, 16'd0, 64'd100, 64'd0);
    send_op(OP_SET_READY, 1'b0, 4'd7, 16'd0, 16'd0, 64'd0, 64'd100);
    send_op(OP_POLL, 1'b0, 4'd0, 16'd0, 16'd0, 64'd100, 64'd0);
    send_op(OP_POLL, 1'b0, 4'd0, 16'd0, 16'd0, 64'd101, 64'd0);
  endtask

  task automatic test_unused_op();
    send_op(OP_NOP, 1'b1, 4'd15, 16'hFFFF, 16'hFFFF, '1, '1);
    send_op(OP_POLL, 1'b0, 4'd0, 16'd0, 16'd0, 64'd102, 64'd0);
  endtask

  task automatic test_pointer_range();
    send_op(OP_CONSUME, 1'b0, 4'd15, 16'd0, 16'hFFFF, 64'd0, 64'd0);
    send_op(OP_SET_READY, 1'b0, 4'd12, 16'd0, 16'd0, 64'd0, 64'd150);
    send_op(OP_POLL, 1'b1, 4'd12, 16'd5, 16'd0, 64'd120, 64'd0);
    send_op(OP_POLL, 1'b0, 4'd0, 16'd0, 16'd0, 64'd160, 64'd0);
    write_reg(REG_ACTIVE_QUEUES, 32'd4);
    send_op(OP_POLL, 1'b1, 4'd2, 16'd3, 16'd0, 64'd200, 64'd0);
    send_op(OP_POLL, 1'b0, 4'd0, 16'd0, 16'd0, 64'd200, 64'd0);
    write_reg(REG_ACTIVE_QUEUES, 32'd0);
    send_op(OP_POLL, 1'b0, 4'd0, 16'd0, 16'd0, 64'd300, 64'd0);
    write_reg(REG_ACTIVE_QUEUES, 32'd31);
  endtask

  task automatic test_burst_limits();
    write_reg(REG_MAX_BURST, 32'd0);
    send_op(OP_POLL, 1'b1, 4'd4, 16'd9, 16'd0, 64'd400, 64'd0);
    write_reg(REG_MAX_BURST, 32'hFFFF);
    send_op(OP_POLL, 1'b1, 4'd9, 16'hFFFF, 16'd0, 64'd401, 64'd0);
    write_reg(REG_MAX_BURST, 32'd1);
    send_op(OP_POLL, 1'b0, 4'd0, 16'd0, 16'd0, 64'd402, 64'd0);
  endtask

  task automatic test_random_traffic();
    int act_set [6];
    int burst_set [6];
    int k;
    int i;
    act_set   = '{16, 5, 1, 31, 9, 0};
    burst_set = '{32, 7, 65535, 1, 0, 20};
    traffic_time = 64'd1000;
    for (k = 0; k < 6; k++) begin
      case (k / 2)
        0:       begin send_idle_pct = 38; recv_idle_pct = 72; end
        1:       begin send_idle_pct = 72; recv_idle_pct = 38; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      write_reg(REG_ACTIVE_QUEUES, act_set[k]);
      write_reg(REG_MAX_BURST, burst_set[k]);
      for (i = 0; i < 100; i++) begin
        if (i == 50) drain();
        send_beat(traffic_beat());
      end
    end
  endtask

  initial begin
    errors        = 0;
    cycles        = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < QUEUES; k++) begin
      pend_cnt[k] = '0;
      ready_at[k] = '0;
    end
    rr_ptr     = '0;
    cfg_active = ACTIVE_RESET;
    cfg_burst  = BURST_RESET;
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_doorbell_grant();
    test_consume_saturation();
    test_ready_time();
    test_unused_op();
    test_pointer_range();
    test_burst_limits();
    test_random_traffic();

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("[doorbell_queue_selector] OK");
    end else begin
      $display("[doorbell_queue_selector] ERROR");
    end
    $finish;
  end

endmodule
